// ===== rtl/lbas_pkg.sv =====
`default_nettype none

package lbas_pkg;

    localparam int GRID_SIZE     = 8;
    localparam int GRID_W        = 3;
    localparam int CELL_TOTAL    = GRID_SIZE * GRID_SIZE;
    localparam int CELL_W        = 6;
    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int POS_W         = 12;
    localparam int PIX_W         = 8;
    localparam int SUM_W         = 27;
    localparam int CNT_W         = 19;
    localparam int QUO_W         = 8;
    localparam int STEP_W        = 3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(64);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(64);

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } cell_entry_t;

    typedef struct packed {
        logic load_pixel;
        logic calc_luma;
        logic calc_weight;
        logic mem_read;
        logic read_drain;
        logic mem_write;
        logic step_cell;
        logic drain_start;
        logic div_start;
        logic div_step;
        logic out_load;
        logic drain_next;
        logic clear_frame;
    } dp_cmd_t;

    typedef struct packed {
        logic cells_done;
        logic frame_end;
        logic div_last;
        logic out_free;
        logic drain_last;
    } dp_sts_t;

    // zero counts as one, anything above the maximum saturates
    function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = v;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIMENSION)) begin
            d = DIM_W'(MAX_DIMENSION);
        end
        return d;
    endfunction

    // one bit per grid column (or row) whose span holds pos
    function automatic logic [GRID_SIZE-1:0] span_mask(input logic [POS_W-1:0] pos,
                                                       input logic [DIM_W-1:0] dim);
        logic [DIM_W+GRID_W:0]  prod;
        logic [DIM_W-1:0]       lo [GRID_SIZE+1];
        logic [DIM_W-1:0]       hi;
        logic [GRID_SIZE-1:0]   mask;
        for (int g = 0; g <= GRID_SIZE; g++) begin
            prod  = (DIM_W+GRID_W+1)'(g) * (DIM_W+GRID_W+1)'(dim);
            lo[g] = DIM_W'(prod >> GRID_W);
        end
        for (int g = 0; g < GRID_SIZE; g++) begin
            hi = lo[g+1];
            if (hi < lo[g] + DIM_W'(1)) begin
                hi = lo[g] + DIM_W'(1);
            end
            if (hi > dim) begin
                hi = dim;
            end
            mask[g] = (DIM_W'(pos) >= lo[g]) && (DIM_W'(pos) < hi);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lbas_ctrl.sv =====
`default_nettype none

module lbas_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lbas_pkg::dp_sts_t sts,
    output lbas_pkg::dp_cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LUMA  = 4'd1;
    localparam logic [3:0] ST_WGT   = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_WRITE = 4'd4;
    localparam logic [3:0] ST_DREAD = 4'd5;
    localparam logic [3:0] ST_DLOAD = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DOUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ST_LUMA;
                end
            end
            ST_LUMA: begin
                cmd.calc_luma = 1'b1;
                state_next    = ST_WGT;
            end
            ST_WGT: begin
                cmd.calc_weight = 1'b1;
                state_next      = ST_READ;
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.mem_write = 1'b1;
                cmd.step_cell = 1'b1;
                if (!sts.cells_done) begin
                    state_next = ST_READ;
                end else if (sts.frame_end) begin
                    cmd.drain_start = 1'b1;
                    state_next      = ST_DREAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DREAD: begin
                cmd.mem_read   = 1'b1;
                cmd.read_drain = 1'b1;
                state_next     = ST_DLOAD;
            end
            ST_DLOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DOUT;
                end
            end
            ST_DOUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.drain_last) begin
                        cmd.clear_frame = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.drain_next = 1'b1;
                        state_next     = ST_DREAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lbas_dp.sv =====
`default_nettype none

module lbas_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_index,
    input  wire logic [lbas_pkg::DIM_W-1:0]          cfg_data,
    input  wire logic [lbas_pkg::PIX_W-1:0]          s_red,
    input  wire logic [lbas_pkg::PIX_W-1:0]          s_green,
    input  wire logic [lbas_pkg::PIX_W-1:0]          s_blue,
    input  wire logic [lbas_pkg::PIX_W-1:0]          s_alpha,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [lbas_pkg::QUO_W-1:0]               m_cell_value,
    output logic [lbas_pkg::CELL_W-1:0]              m_cell_index,
    output logic                                     m_last_cell,
    input  wire lbas_pkg::dp_cmd_t                   cmd,
    output lbas_pkg::dp_sts_t                        sts
);

    localparam int GRID  = lbas_pkg::GRID_SIZE;
    localparam int GW    = lbas_pkg::GRID_W;
    localparam int DW    = lbas_pkg::DIM_W;
    localparam int PW    = lbas_pkg::POS_W;
    localparam int SW    = lbas_pkg::SUM_W;
    localparam int CW    = lbas_pkg::CNT_W;
    localparam int QW    = lbas_pkg::QUO_W;
    localparam int REM_W = SW + 1;
    localparam int DSR_W = CW + QW - 1;

    // configuration and frame position
    logic [DW-1:0] width_reg, height_reg;
    logic [DW-1:0] dim_w, dim_h;
    logic [PW-1:0] col_reg, row_reg;
    logic          frame_end_reg;
    logic          clear_all;
    logic          col_wrap, row_wrap;

    // pixel arithmetic
    logic [lbas_pkg::PIX_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0]                luma_sum;
    logic [7:0]                 luma_reg;
    logic [15:0]                prod_reg;
    logic [15:0]                wgt_sum;
    logic [7:0]                 weighted;

    // cell walk
    logic [GRID-1:0] col_mask, row_mask;
    logic [GW-1:0]   col_first, col_last, row_first, row_last;
    logic [GW-1:0]   col_first_reg, col_last_reg, row_first_reg, row_last_reg;
    logic [GW-1:0]   gx_reg, gy_reg;

    // accumulator memory
    lbas_pkg::cell_entry_t                mem [lbas_pkg::CELL_TOTAL];
    lbas_pkg::cell_entry_t                rd_entry_reg;
    lbas_pkg::cell_entry_t                wr_entry;
    logic                                 rd_valid_reg;
    logic [lbas_pkg::CELL_TOTAL-1:0]      valid_reg;
    logic [lbas_pkg::CELL_W-1:0]          rd_addr, wr_addr;
    logic [SW-1:0]                        cur_sum;
    logic [CW-1:0]                        cur_count;

    // drain and divider
    logic [lbas_pkg::CELL_W-1:0] drain_idx_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [DSR_W-1:0]            dsr_reg;
    logic [QW-1:0]               quo_reg;
    logic [lbas_pkg::STEP_W-1:0] step_reg;
    logic                        zero_cnt_reg;
    logic                        rem_ge;

    // output register
    logic                        m_valid_reg;
    logic [QW-1:0]               value_reg;
    logic [lbas_pkg::CELL_W-1:0] index_reg;
    logic                        last_reg;

    assign dim_w     = lbas_pkg::effective_dim(width_reg);
    assign dim_h     = lbas_pkg::effective_dim(height_reg);
    assign clear_all = cmd.clear_frame || cfg_wr_en;
    assign col_wrap  = (DW'(col_reg) + DW'(1)) >= dim_w;
    assign row_wrap  = (DW'(row_reg) + DW'(1)) >= dim_h;

    assign col_mask = lbas_pkg::span_mask(col_reg, dim_w);
    assign row_mask = lbas_pkg::span_mask(row_reg, dim_h);

    always_comb begin
        col_first = '0;
        row_first = '0;
        col_last  = '0;
        row_last  = '0;
        for (int g = GRID - 1; g >= 0; g--) begin
            if (col_mask[g]) col_first = GW'(g);
            if (row_mask[g]) row_first = GW'(g);
        end
        for (int g = 0; g < GRID; g++) begin
            if (col_mask[g]) col_last = GW'(g);
            if (row_mask[g]) row_last = GW'(g);
        end
    end

    assign luma_sum = 16'd54 * 16'(red_reg) + 16'd183 * 16'(green_reg)
                    + 16'd19 * 16'(blue_reg) + 16'd128;
    // divide by 255: exact for every product up to 255*255 + 127
    assign wgt_sum  = prod_reg + 16'(prod_reg[15:8]) + 16'd1;
    assign weighted = wgt_sum[15:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lbas_pkg::WIDTH_RESET;
            height_reg <= lbas_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lbas_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                lbas_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // position advance happens when the pixel is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            frame_end_reg <= 1'b0;
        end else if (clear_all) begin
            col_reg       <= '0;
            row_reg       <= '0;
            frame_end_reg <= 1'b0;
        end else if (cmd.load_pixel) begin
            frame_end_reg <= col_wrap && row_wrap;
            if (col_wrap) begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + PW'(1);
            end else begin
                col_reg <= col_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            red_reg       <= s_red;
            green_reg     <= s_green;
            blue_reg      <= s_blue;
            alpha_reg     <= s_alpha;
            col_first_reg <= col_first;
            col_last_reg  <= col_last;
            row_first_reg <= row_first;
            row_last_reg  <= row_last;
            gx_reg        <= col_first;
            gy_reg        <= row_first;
        end else if (cmd.step_cell) begin
            if (gx_reg != col_last_reg) begin
                gx_reg <= gx_reg + GW'(1);
            end else begin
                gx_reg <= col_first_reg;
                gy_reg <= gy_reg + GW'(1);
            end
        end
        if (cmd.calc_luma) begin
            luma_reg <= luma_sum[15:8];
        end
        if (cmd.calc_weight) begin
            prod_reg <= 16'(luma_reg) * 16'(alpha_reg) + 16'd127;
        end
    end

    assign wr_addr   = {gy_reg, gx_reg};
    assign rd_addr   = cmd.read_drain ? drain_idx_reg : wr_addr;
    assign cur_sum   = rd_valid_reg ? rd_entry_reg.sum   : '0;
    assign cur_count = rd_valid_reg ? rd_entry_reg.count : '0;

    always_comb begin
        wr_entry.sum   = cur_sum + SW'(weighted);
        wr_entry.count = cur_count + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.mem_read) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear_all) begin
                valid_reg <= '0;
            end else if (cmd.mem_write) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.mem_read) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_idx_reg <= '0;
        end else if (cmd.drain_start) begin
            drain_idx_reg <= '0;
        end else if (cmd.drain_next) begin
            drain_idx_reg <= drain_idx_reg + lbas_pkg::CELL_W'(1);
        end
    end

    // restoring divide, one quotient bit per step, quotient known below 256
    assign rem_ge = rem_reg >= REM_W'(dsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.div_start) begin
            step_reg <= lbas_pkg::STEP_W'(QW - 1);
        end else if (cmd.div_step) begin
            step_reg <= step_reg - lbas_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg      <= REM_W'(cur_sum) + REM_W'(cur_count >> 1);
            dsr_reg      <= {cur_count, {(QW-1){1'b0}}};
            quo_reg      <= '0;
            zero_cnt_reg <= (cur_count == '0);
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - REM_W'(dsr_reg);
            end
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            value_reg <= zero_cnt_reg ? '0 : quo_reg;
            index_reg <= drain_idx_reg;
            last_reg  <= sts.drain_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_value = value_reg;
    assign m_cell_index = index_reg;
    assign m_last_cell  = last_reg;

    always_comb begin
        sts.cells_done = (gx_reg == col_last_reg) && (gy_reg == row_last_reg);
        sts.frame_end  = frame_end_reg;
        sts.div_last   = (step_reg == '0);
        sts.out_free   = !m_valid_reg || m_ready;
        sts.drain_last = (drain_idx_reg == lbas_pkg::CELL_W'(lbas_pkg::CELL_TOTAL - 1));
    end

endmodule

`default_nettype wire

// ===== rtl/luma_block_average_signature.sv =====
// Luma block-average signature: an 8x8 grid of mean alpha-weighted luma.
//
// Input channel (s_valid/s_ready): one RGBA pixel per transfer, raster order,
// image size taken from the width and height registers (0 counts as 1,
// values above 4096 saturate). Writing either register restarts the frame.
// Result channel (m_valid/m_ready): after the last pixel of a frame, 64
// transfers carry the rounded cell averages in row-major order; m_last_cell
// marks cell 63.
// Per pixel: load, luma, alpha weighting, then a read-modify-write for each
// of the N grid cells that hold it; N = 1 when both dimensions are >= 8.
// Each cell costs one read and one write on the single-port accumulator
// memory. The drain after the last pixel reads each cell, runs the 8-step
// serial divider on it and loads the result into the output register.
// A stalled receiver holds the output register; the drain waits behind it
// and no pixel is taken until the last cell is in the output register.
// Reset (aresetn low, synchronous) clears the position, the per-cell valid
// bits and the output valid; no clearing pass over the memory is needed.
`default_nettype none

module luma_block_average_signature (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [lbas_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lbas_pkg::PIX_W-1:0]      s_red,
    input  wire logic [lbas_pkg::PIX_W-1:0]      s_green,
    input  wire logic [lbas_pkg::PIX_W-1:0]      s_blue,
    input  wire logic [lbas_pkg::PIX_W-1:0]      s_alpha,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [lbas_pkg::QUO_W-1:0]           m_cell_value,
    output logic [lbas_pkg::CELL_W-1:0]          m_cell_index,
    output logic                                 m_last_cell
);

    lbas_pkg::dp_cmd_t cmd;
    lbas_pkg::dp_sts_t sts;

    // sequencer: pixel load, per-cell read-modify-write, drain and divide
    lbas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, accumulator memory, divider and output register
    lbas_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_alpha      (s_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_value (m_cell_value),
        .m_cell_index (m_cell_index),
        .m_last_cell  (m_last_cell),
        .cmd          (cmd),
        .sts          (sts)
    );

    // the final-cell flag travels only with the last cell index
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_cell |->
            m_cell_index == lbas_pkg::CELL_W'(lbas_pkg::CELL_TOTAL - 1))
        else $error("last_cell on a cell other than the final one");

    // every accumulator write comes in the cycle after its pixel read
    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_write |-> $past(cmd.mem_read) && !$past(cmd.read_drain))
        else $error("accumulator write without a preceding read");

    // never overwrite a result the receiver has not taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid || m_ready)
        else $error("output register overwritten while stalled");

    // no pixel is taken while the divider runs
    a_no_take_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready)
        else $error("input ready during drain");

endmodule

`default_nettype wire
